[design/mtfa_pkg.sv]
`default_nettype none
package mtfa_pkg;

	localparam int DEF_MAX_POINTS = 32;

	localparam int TYPE_W        = 16;
	localparam int CODE_W        = 16;
	localparam int VALUE_W       = 32;
	localparam int FRAME_PTS_W   = 6;
	localparam int IDENT_W       = 31;
	localparam int APB_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;

	localparam logic [TYPE_W-1:0] EVT_SYNC = 16'h0000;
	localparam logic [TYPE_W-1:0] EVT_ABS  = 16'h0003;

	localparam logic [CODE_W-1:0] SYNC_REPORT    = 16'h0000;
	localparam logic [CODE_W-1:0] SYNC_MT_REPORT = 16'h0002;
	localparam logic [CODE_W-1:0] ABS_X_CODE     = 16'h0035;
	localparam logic [CODE_W-1:0] ABS_Y_CODE     = 16'h0036;
	localparam logic [CODE_W-1:0] ABS_ID_CODE    = 16'h0039;

	localparam logic REG_TIDS = 1'b0;

	typedef struct packed {
		logic we_x;
		logic we_y;
		logic we_id;
		logic rd_en;
	} mem_ctl_t;

endpackage
`default_nettype wire

[design/mtfa_if.sv]
`default_nettype none
interface mtfa_evt_if;
	logic                          valid;
	logic                          ready;
	logic [mtfa_pkg::TYPE_W-1:0]   event_type;
	logic [mtfa_pkg::CODE_W-1:0]   event_code;
	logic signed [mtfa_pkg::VALUE_W-1:0] event_value;

	modport source (output valid, event_type, event_code, event_value, input ready);
	modport sink (input valid, event_type, event_code, event_value, output ready);
endinterface

interface mtfa_res_if;
	logic                               valid;
	logic                               ready;
	logic [mtfa_pkg::FRAME_PTS_W-1:0]   frame_points;
	logic                               point_valid;
	logic signed [mtfa_pkg::VALUE_W-1:0] point_x;
	logic signed [mtfa_pkg::VALUE_W-1:0] point_y;
	logic [mtfa_pkg::IDENT_W-1:0]       point_ident;
	logic                               last_of_frame;

	modport source (output valid, frame_points, point_valid, point_x, point_y, point_ident,
		last_of_frame, input ready);
	modport sink (input valid, frame_points, point_valid, point_x, point_y, point_ident,
		last_of_frame, output ready);
endinterface
`default_nettype wire

[design/multitouch_frame_assembler.sv]
// a report beat moves the sequencer to ST_EMPTY for an empty frame, else to ST_ISSUE; no new
// event is taken until the frame has drained, and other events are accepted while idle. Each
// stored point passes ST_ISSUE, a registered read of the point memory, then ST_WAIT, where
// the id write-back and the output load happen once the output is free, as in ST_EMPTY
// reset: arst_n clears counters, seen flags, id valid bits and the config register; no sweep
`default_nettype none
module multitouch_frame_assembler #(
	parameter int MAX_POINTS = mtfa_pkg::DEF_MAX_POINTS
) (
	input  wire                               clk,
	input  wire                               arst_n,
	mtfa_evt_if.sink                          evt,
	mtfa_res_if.source                        res,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [mtfa_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire  [mtfa_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [mtfa_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import mtfa_pkg::*;

	localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	logic               tids_q;
	mem_ctl_t           mem_ctl;
	logic [IDX_W-1:0]   wr_addr;
	logic [IDX_W-1:0]   rd_addr;
	logic [VALUE_W-1:0] wr_x;
	logic [VALUE_W-1:0] wr_y;
	logic [VALUE_W-1:0] wr_id;
	logic [VALUE_W-1:0] rd_x;
	logic [VALUE_W-1:0] rd_y;
	logic [VALUE_W-1:0] rd_id;

	assign pready = 1'b1;
	assign prdata = (paddr[APB_ADDR_W-1] == REG_TIDS) ? APB_DATA_W'(tids_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tids_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1] == REG_TIDS) begin
			tids_q <= pwdata[0];
		end
	end

	mtfa_seq #(
		.MAX_POINTS (MAX_POINTS),
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.evt     (evt),
		.res     (res),
		.tids    (tids_q),
		.mem_ctl (mem_ctl),
		.wr_addr (wr_addr),
		.wr_x    (wr_x),
		.wr_y    (wr_y),
		.wr_id   (wr_id),
		.rd_addr (rd_addr),
		.rd_x    (rd_x),
		.rd_y    (rd_y),
		.rd_id   (rd_id)
	);

	mtfa_point_mem #(
		.MAX_POINTS (MAX_POINTS),
		.IDX_W      (IDX_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.wr_addr (wr_addr),
		.wr_x    (wr_x),
		.wr_y    (wr_y),
		.wr_id   (wr_id),
		.rd_addr (rd_addr),
		.rd_x    (rd_x),
		.rd_y    (rd_y),
		.rd_id   (rd_id)
	);

endmodule
`default_nettype wire

[design/mtfa_point_mem.sv]
`default_nettype none
module mtfa_point_mem #(
	parameter int MAX_POINTS = mtfa_pkg::DEF_MAX_POINTS,
	parameter int IDX_W      = 5
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire  mtfa_pkg::mem_ctl_t       ctl,
	input  wire  [IDX_W-1:0]               wr_addr,
	input  wire  [mtfa_pkg::VALUE_W-1:0]   wr_x,
	input  wire  [mtfa_pkg::VALUE_W-1:0]   wr_y,
	input  wire  [mtfa_pkg::VALUE_W-1:0]   wr_id,
	input  wire  [IDX_W-1:0]               rd_addr,
	output logic [mtfa_pkg::VALUE_W-1:0]   rd_x,
	output logic [mtfa_pkg::VALUE_W-1:0]   rd_y,
	output logic [mtfa_pkg::VALUE_W-1:0]   rd_id
);
	import mtfa_pkg::*;

	logic [VALUE_W-1:0] mem_x  [MAX_POINTS];
	logic [VALUE_W-1:0] mem_y  [MAX_POINTS];
	logic [VALUE_W-1:0] mem_id [MAX_POINTS];
	logic [MAX_POINTS-1:0] id_vld_q;
	logic [VALUE_W-1:0] rd_id_s1;
	logic rd_vld_s1;

	always_ff @(posedge clk) begin
		if (ctl.we_x) begin
			mem_x[wr_addr] <= wr_x;
		end
		if (ctl.we_y) begin
			mem_y[wr_addr] <= wr_y;
		end
		if (ctl.we_id) begin
			mem_id[wr_addr] <= wr_id;
		end
		if (ctl.rd_en) begin
			rd_x     <= mem_x[rd_addr];
			rd_y     <= mem_y[rd_addr];
			rd_id_s1 <= mem_id[rd_addr];
		end
	end

	// ident entries read as zero until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_vld_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (ctl.we_id) begin
				id_vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_vld_s1 <= id_vld_q[rd_addr];
			end
		end
	end

	assign rd_id = rd_vld_s1 ? rd_id_s1 : '0;

endmodule
`default_nettype wire

[design/mtfa_seq.sv]
`default_nettype none
module mtfa_seq #(
	parameter int MAX_POINTS = mtfa_pkg::DEF_MAX_POINTS,
	parameter int IDX_W      = 5,
	parameter int CNT_W      = 6
) (
	input  wire                            clk,
	input  wire                            arst_n,
	mtfa_evt_if.sink                       evt,
	mtfa_res_if.source                     res,
	input  wire                            tids,
	output mtfa_pkg::mem_ctl_t             mem_ctl,
	output logic [IDX_W-1:0]               wr_addr,
	output logic [mtfa_pkg::VALUE_W-1:0]   wr_x,
	output logic [mtfa_pkg::VALUE_W-1:0]   wr_y,
	output logic [mtfa_pkg::VALUE_W-1:0]   wr_id,
	output logic [IDX_W-1:0]               rd_addr,
	input  wire  [mtfa_pkg::VALUE_W-1:0]   rd_x,
	input  wire  [mtfa_pkg::VALUE_W-1:0]   rd_y,
	input  wire  [mtfa_pkg::VALUE_W-1:0]   rd_id
);
	import mtfa_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_ISSUE = 2'd2;
	localparam logic [1:0] ST_WAIT  = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] frame_q;
	logic [IDX_W-1:0] idx_q;
	logic             seen_x_q;
	logic             seen_y_q;
	logic             res_valid_q;

	logic accept;
	logic full;
	logic is_report;
	logic is_mt_report;
	logic is_abs;
	logic do_commit;
	logic out_free;
	logic drain_last;
	logic res_load;

	assign accept       = evt.valid && evt.ready;
	assign full         = (count_q == CNT_W'(MAX_POINTS));
	assign is_report    = (evt.event_type == EVT_SYNC) && (evt.event_code == SYNC_REPORT);
	assign is_mt_report = (evt.event_type == EVT_SYNC) && (evt.event_code == SYNC_MT_REPORT);
	assign is_abs       = (evt.event_type == EVT_ABS) && !full;
	assign do_commit    = is_mt_report && seen_x_q && seen_y_q && !full;
	assign out_free     = !res_valid_q || res.ready;
	assign drain_last   = ((CNT_W'(idx_q) + CNT_W'(1)) == frame_q);
	assign res_load     = out_free && ((state_q == ST_EMPTY) || (state_q == ST_WAIT));

	assign evt.ready = (state_q == ST_IDLE);
	assign res.valid = res_valid_q;
	assign rd_addr   = idx_q;
	assign wr_x      = evt.event_value;
	assign wr_y      = evt.event_value;

	always_comb begin
		mem_ctl = '0;
		wr_addr = count_q[IDX_W-1:0];
		wr_id   = evt.event_value;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_abs) begin
					mem_ctl.we_x  = (evt.event_code == ABS_X_CODE);
					mem_ctl.we_y  = (evt.event_code == ABS_Y_CODE);
					mem_ctl.we_id = (evt.event_code == ABS_ID_CODE);
				end else if (accept && do_commit && !tids) begin
					mem_ctl.we_id = 1'b1;
					wr_id         = VALUE_W'(count_q);
				end
			end
			ST_ISSUE: begin
				mem_ctl.rd_en = 1'b1;
			end
			ST_WAIT: begin
				// reported slots get id -1
				if (out_free) begin
					mem_ctl.we_id = 1'b1;
					wr_addr       = idx_q;
					wr_id         = '1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			frame_q     <= '0;
			idx_q       <= '0;
			seen_x_q    <= 1'b0;
			seen_y_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_report) begin
							frame_q  <= count_q;
							count_q  <= '0;
							idx_q    <= '0;
							seen_x_q <= 1'b0;
							seen_y_q <= 1'b0;
							state_q  <= (count_q == '0) ? ST_EMPTY : ST_ISSUE;
						end else if (do_commit) begin
							count_q  <= count_q + CNT_W'(1);
							seen_x_q <= 1'b0;
							seen_y_q <= 1'b0;
						end else if (is_abs) begin
							if (evt.event_code == ABS_X_CODE) begin
								seen_x_q <= 1'b1;
							end
							if (evt.event_code == ABS_Y_CODE) begin
								seen_y_q <= 1'b1;
							end
						end
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (out_free) begin
						if (drain_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_ISSUE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EMPTY && out_free) begin
			res.frame_points  <= '0;
			res.point_valid   <= 1'b0;
			res.point_x       <= '0;
			res.point_y       <= '0;
			res.point_ident   <= '0;
			res.last_of_frame <= 1'b1;
		end else if (state_q == ST_WAIT && out_free) begin
			res.frame_points  <= FRAME_PTS_W'(frame_q);
			res.point_valid   <= 1'b1;
			res.point_x       <= rd_x;
			res.point_y       <= rd_y;
			res.point_ident   <= rd_id[VALUE_W-1] ? '0 : rd_id[IDENT_W-1:0];
			res.last_of_frame <= drain_last;
		end
	end

endmodule
`default_nettype wire

[design/mtfa_checker.sv]
`default_nettype none
module mtfa_checker (
	input wire          clk,
	input wire          arst_n,
	mtfa_evt_if.sink    evt,
	mtfa_res_if.source  res
);

	// empty frame beat is always a lone last beat with zero count
	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.point_valid |-> res.last_of_frame && res.frame_points == 6'd0)
		else $error("empty frame beat malformed");

	// a one-point frame ends on its only beat
	a_single_point: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.point_valid && res.frame_points == 6'd1 |-> res.last_of_frame)
		else $error("single point frame missing last flag");

	// no new event taken while a frame is still draining
	a_drain_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.point_valid && !res.last_of_frame |-> !evt.ready)
		else $error("event accepted during frame drain");

	// stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.point_x) && $stable(res.point_y)
			&& $stable(res.point_ident) && $stable(res.last_of_frame))
		else $error("result beat changed while stalled");

endmodule

bind multitouch_frame_assembler mtfa_checker u_mtfa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.evt    (evt),
	.res    (res)
);
`default_nettype wire
